>>> hdl/rotation_matrix_inverse_3x3_core_assert.svh
// Assertion macros for the matrix inverse core.
`ifndef ROTATION_MATRIX_INVERSE_3X3_CORE_ASSERT_SVH
`define ROTATION_MATRIX_INVERSE_3X3_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RMI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define RMI_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/rmi_pkg.sv
package rmi_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 24;
   localparam int NUM_ELEM  = 9;

   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int COF_BITS  = 2 * WORD_BITS + 1;
   localparam int PART_BITS = 2 * WORD_BITS + 1;
   localparam int DET_BITS  = 3 * WORD_BITS + 1;
   localparam int SUM_BITS  = DET_BITS + 2;
   localparam int MAG_BITS  = 3 * WORD_BITS;
   localparam int DEN_BITS  = 3 * WORD_BITS + 1;
   localparam int NUM_A     = 2 * WORD_BITS + 2 * FRAC_BITS + 2;
   localparam int NUM_B     = 4 * WORD_BITS + 1;
   localparam int REM_BITS  = (NUM_A > NUM_B) ? NUM_A : NUM_B;
   localparam int QUO_BITS  = WORD_BITS + 1;
   localparam int SCL_BITS  = DET_BITS + 11;
   localparam int BND_BITS  = 3 * FRAC_BITS + 11;
   localparam int CMP_BITS  = ((SCL_BITS > BND_BITS) ? SCL_BITS : BND_BITS) + 1;

   // rotation window: 0.999 < det < 1.001, det at scale 2^(3F), compared as 1000*det
   localparam logic signed [CMP_BITS-1:0] ROT_LO = CMP_BITS'(999) <<< (3 * FRAC_BITS);
   localparam logic signed [CMP_BITS-1:0] ROT_HI = CMP_BITS'(1001) <<< (3 * FRAC_BITS);

   localparam logic [WORD_BITS-1:0] SAT_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] SAT_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

   // cofactor i = a[p]*a[q] - a[r]*a[s], row-major element index
   localparam int COF_SEL [NUM_ELEM][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};
   localparam int DET_COF [3] = '{0, 3, 6};
   localparam int TRN_SEL [NUM_ELEM] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

   typedef struct packed {
      logic signed [WORD_BITS-1:0] in_r0c0;
      logic signed [WORD_BITS-1:0] in_r0c1;
      logic signed [WORD_BITS-1:0] in_r0c2;
      logic signed [WORD_BITS-1:0] in_r1c0;
      logic signed [WORD_BITS-1:0] in_r1c1;
      logic signed [WORD_BITS-1:0] in_r1c2;
      logic signed [WORD_BITS-1:0] in_r2c0;
      logic signed [WORD_BITS-1:0] in_r2c1;
      logic signed [WORD_BITS-1:0] in_r2c2;
   } rmi_req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] out_r0c0;
      logic signed [WORD_BITS-1:0] out_r0c1;
      logic signed [WORD_BITS-1:0] out_r0c2;
      logic signed [WORD_BITS-1:0] out_r1c0;
      logic signed [WORD_BITS-1:0] out_r1c1;
      logic signed [WORD_BITS-1:0] out_r1c2;
      logic signed [WORD_BITS-1:0] out_r2c0;
      logic signed [WORD_BITS-1:0] out_r2c1;
      logic signed [WORD_BITS-1:0] out_r2c2;
      logic                        singular;
      logic                        used_transpose;
   } rmi_rsp_type;

   typedef logic [NUM_ELEM-1:0][WORD_BITS-1:0] rmi_elem_type;
   typedef logic [NUM_ELEM-1:0][COF_BITS-1:0]  rmi_cof_type;
   typedef logic [NUM_ELEM-1:0][REM_BITS-1:0]  rmi_num_type;
   typedef logic [NUM_ELEM-1:0][QUO_BITS-1:0]  rmi_quo_type;

   typedef struct packed {
      rmi_elem_type        elem;
      rmi_cof_type         cof;
      logic [MAG_BITS-1:0] dabs;
      logic                dneg;
      logic                transpose;
      logic                singular;
   } rmi_task_type;

   typedef struct packed {
      rmi_elem_type        elem;
      logic [NUM_ELEM-1:0] neg;
      logic                transpose;
      logic                singular;
   } rmi_side_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rmi_q_status_type;

endpackage

>>> hdl/rotation_matrix_inverse_3x3_core.sv
// 3x3 matrix inverse, signed Q8.24 elements, one matrix per request.
// Request channel: a request is taken at a rising edge with start high and
// busy low; req_data holds the nine elements, row-major.
// Result channel: rsp_strobe is high for one cycle with rsp_data holding the
// inverse and the singular / used_transpose flags. Results leave in request
// order and cannot be held off by the receiver.
// Throughput: one request per cycle, sustained while busy stays low. The front end (cofactors,
// determinant, rotation test) is a six-stage pipeline feeding a short queue;
// the back end divides all nine cofactors by the determinant one quotient
// bit per stage, WORD_BITS + 1 stages, nine lanes side by side.
// busy only rises if the queue fills, which the free-running back end
// prevents for any QUEUE_DEPTH above 1; start is then never refused.
// Reset (synchronous, active high) empties both pipelines and the queue;
// requests in flight are dropped.
`include "rotation_matrix_inverse_3x3_core_assert.svh"

module rotation_matrix_inverse_3x3_core import rmi_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  rmi_req_type req_data,
   output logic        rsp_strobe,
   output rmi_rsp_type rsp_data
);

   logic             q_push;
   rmi_task_type     q_push_data;
   logic             q_pop_valid;
   rmi_task_type     q_pop_data;
   rmi_q_status_type q_status;

   rmi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_data   (req_data),
      .out_valid (q_push),
      .out_task  (q_push_data)
   );

   rmi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop_valid (q_pop_valid),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   rmi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_pop_valid),
      .in_task    (q_pop_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   assign busy = q_status.full;

   `RMI_ASSERT_IMP(a_flags_exclusive, rsp_strobe, !(rsp_data.singular && rsp_data.used_transpose), "singular and transpose flags both set")
   `RMI_ASSERT_IMP(a_singular_zero, rsp_strobe && rsp_data.singular, rsp_data.out_r0c0 == '0 && rsp_data.out_r0c1 == '0 && rsp_data.out_r0c2 == '0 && rsp_data.out_r1c0 == '0 && rsp_data.out_r1c1 == '0 && rsp_data.out_r1c2 == '0 && rsp_data.out_r2c0 == '0 && rsp_data.out_r2c1 == '0 && rsp_data.out_r2c2 == '0, "singular result with nonzero element")
   `RMI_ASSERT_IMP(a_queue_no_overflow, q_push, !q_status.full, "push into full queue")
   `RMI_ASSERT_NXT(a_queue_drains, !q_status.empty, q_pop_valid, "queue held an entry without popping")

endmodule

>>> hdl/rmi_front.sv
module rmi_front import rmi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  rmi_req_type  in_data,
   output logic         out_valid,
   output rmi_task_type out_task
);

   logic [5:0] vld_ff, vld_in;

   rmi_elem_type elem0_ff, elem0_in, elem1_ff, elem2_ff, elem3_ff, elem4_ff, elem5_ff;
   logic [NUM_ELEM-1:0][PROD_BITS-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   rmi_cof_type cof2_ff, cof2_in, cof3_ff, cof4_ff, cof5_ff;
   logic [2:0][PART_BITS-1:0] plo_ff, plo_in, phi_ff, phi_in;
   logic [DET_BITS-1:0] det4_ff, det4_in, det_neg;
   logic signed [SUM_BITS-1:0] acc;
   logic signed [CMP_BITS-1:0] scl5_ff, scl5_in, dsx;
   logic [MAG_BITS-1:0] dabs5_ff, dabs5_in;
   logic dneg5_ff, dzero5_ff;
   logic transpose;

   assign vld_in = {vld_ff[4:0], in_valid};

   always_comb begin
      elem0_in[0] = in_data.in_r0c0;
      elem0_in[1] = in_data.in_r0c1;
      elem0_in[2] = in_data.in_r0c2;
      elem0_in[3] = in_data.in_r1c0;
      elem0_in[4] = in_data.in_r1c1;
      elem0_in[5] = in_data.in_r1c2;
      elem0_in[6] = in_data.in_r2c0;
      elem0_in[7] = in_data.in_r2c1;
      elem0_in[8] = in_data.in_r2c2;
   end

   always_comb begin
      for (int i = 0; i < NUM_ELEM; i++) begin
         prod_a_in[i] = $signed(elem0_ff[COF_SEL[i][0]]) * $signed(elem0_ff[COF_SEL[i][1]]);
         prod_b_in[i] = $signed(elem0_ff[COF_SEL[i][2]]) * $signed(elem0_ff[COF_SEL[i][3]]);
         cof2_in[i]   = COF_BITS'($signed(prod_a_ff[i])) - COF_BITS'($signed(prod_b_ff[i]));
      end
   end

   // determinant terms: element times cofactor split into low (unsigned) and high (signed) halves
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         plo_in[j] = $signed(elem2_ff[j]) *
                     $signed({1'b0, cof2_ff[DET_COF[j]][WORD_BITS-1:0]});
         phi_in[j] = $signed(elem2_ff[j]) *
                     $signed(cof2_ff[DET_COF[j]][COF_BITS-1:WORD_BITS]);
      end
   end

   always_comb begin
      acc = '0;
      for (int j = 0; j < 3; j++) begin
         acc = acc + (SUM_BITS'($signed(phi_ff[j])) <<< WORD_BITS)
                   + SUM_BITS'($signed(plo_ff[j]));
      end
      det4_in = acc[DET_BITS-1:0];
   end

   always_comb begin
      dsx      = CMP_BITS'($signed(det4_ff));
      scl5_in  = (dsx <<< 10) - (dsx <<< 4) - (dsx <<< 3);
      det_neg  = ~det4_ff + DET_BITS'(1);
      dabs5_in = det4_ff[DET_BITS-1] ? det_neg[MAG_BITS-1:0] : det4_ff[MAG_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      elem0_ff  <= elem0_in;
      elem1_ff  <= elem0_ff;
      elem2_ff  <= elem1_ff;
      elem3_ff  <= elem2_ff;
      elem4_ff  <= elem3_ff;
      elem5_ff  <= elem4_ff;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      cof2_ff   <= cof2_in;
      cof3_ff   <= cof2_ff;
      cof4_ff   <= cof3_ff;
      cof5_ff   <= cof4_ff;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      det4_ff   <= det4_in;
      scl5_ff   <= scl5_in;
      dabs5_ff  <= dabs5_in;
      dneg5_ff  <= det4_ff[DET_BITS-1];
      dzero5_ff <= (det4_ff == '0);
   end

   assign transpose = (scl5_ff > ROT_LO) && (scl5_ff < ROT_HI);

   assign out_valid          = vld_ff[5];
   assign out_task.elem      = elem5_ff;
   assign out_task.cof       = cof5_ff;
   assign out_task.dabs      = dabs5_ff;
   assign out_task.dneg      = dneg5_ff;
   assign out_task.transpose = transpose;
   assign out_task.singular  = dzero5_ff & ~transpose;

endmodule

>>> hdl/rmi_queue.sv
module rmi_queue import rmi_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rmi_task_type     push_data,
   output logic             pop_valid,
   output rmi_task_type     pop_data,
   output rmi_q_status_type status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rmi_task_type mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic pop_valid_ff;
   rmi_task_type pop_data_ff;
   logic pop;

   // the back end never stalls: drain whenever something is held
   assign pop = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         pop_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         pop_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (pop) begin
         pop_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign pop_valid    = pop_valid_ff;
   assign pop_data     = pop_data_ff;
   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

>>> hdl/rmi_div.sv
module rmi_div import rmi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  rmi_num_type         in_num,
   input  logic [DEN_BITS-1:0] in_den,
   input  rmi_side_type        in_side,
   output logic                out_valid,
   output rmi_quo_type         out_quo,
   output rmi_side_type        out_side
);

   // one quotient bit per stage, MSB (overflow bit) first, nine lanes share the divisor
   rmi_num_type         rem_ff  [QUO_BITS-1];
   logic [DEN_BITS-1:0] den_ff  [QUO_BITS-1];
   rmi_quo_type         quo_ff  [QUO_BITS];
   rmi_side_type        side_ff [QUO_BITS];
   logic                vld_ff  [QUO_BITS];

   for (genvar s = 0; s < QUO_BITS; s++) begin : g_stage
      localparam int K = QUO_BITS - 1 - s;
      rmi_num_type         rem_src, rem_nx;
      rmi_quo_type         quo_src, quo_nx;
      logic [DEN_BITS-1:0] den_src;
      rmi_side_type        side_src;
      logic                vld_src;
      logic [REM_BITS-1:0] dsh;

      if (s == 0) begin : g_first
         assign rem_src  = in_num;
         assign quo_src  = '0;
         assign den_src  = in_den;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign quo_src  = quo_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign side_src = side_ff[s-1];
         assign vld_src  = vld_ff[s-1];
      end

      always_comb begin
         dsh = REM_BITS'(den_src) << K;
         for (int i = 0; i < NUM_ELEM; i++) begin
            if (rem_src[i] >= dsh) begin
               rem_nx[i] = rem_src[i] - dsh;
               quo_nx[i] = {quo_src[i][QUO_BITS-2:0], 1'b1};
            end else begin
               rem_nx[i] = rem_src[i];
               quo_nx[i] = {quo_src[i][QUO_BITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_src;
         end
         quo_ff[s]  <= quo_nx;
         side_ff[s] <= side_src;
      end

      if (s < QUO_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[s] <= rem_nx;
            den_ff[s] <= den_src;
         end
      end
   end

   assign out_valid = vld_ff[QUO_BITS-1];
   assign out_quo   = quo_ff[QUO_BITS-1];
   assign out_side  = side_ff[QUO_BITS-1];

endmodule

>>> hdl/rmi_back.sv
module rmi_back import rmi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  rmi_task_type in_task,
   output logic         rsp_strobe,
   output rmi_rsp_type  rsp_data
);

   rmi_num_type         num_ff, num_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   rmi_side_type        side_ff, side_in;
   logic                vld_ff;

   logic                div_valid;
   rmi_quo_type         div_quo;
   rmi_side_type        div_side;

   logic [COF_BITS-1:0]  cneg_val;
   logic [PROD_BITS-1:0] cmag;

   logic [NUM_ELEM-1:0][WORD_BITS-1:0] res;
   logic [WORD_BITS-1:0] qlow;
   logic big, neg;
   rmi_rsp_type rsp_data_ff, rsp_data_in;
   logic rsp_strobe_ff;

   // numerator 2|C|*2^(2F) + |D| over 2|D| gives rounding to nearest, ties away
   always_comb begin
      cneg_val = '0;
      cmag     = '0;
      for (int i = 0; i < NUM_ELEM; i++) begin
         cneg_val       = ~in_task.cof[i] + COF_BITS'(1);
         cmag           = in_task.cof[i][COF_BITS-1] ? cneg_val[PROD_BITS-1:0]
                                                     : in_task.cof[i][PROD_BITS-1:0];
         num_in[i]      = (REM_BITS'(cmag) << (2 * FRAC_BITS + 1)) + REM_BITS'(in_task.dabs);
         side_in.neg[i] = in_task.cof[i][COF_BITS-1] ^ in_task.dneg;
         side_in.elem[i] = in_task.elem[TRN_SEL[i]];
      end
      den_in            = {in_task.dabs, 1'b0};
      side_in.transpose = in_task.transpose;
      side_in.singular  = in_task.singular;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_valid;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      side_ff <= side_in;
   end

   rmi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_side   (side_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   always_comb begin
      qlow = '0;
      big  = 1'b0;
      neg  = 1'b0;
      for (int i = 0; i < NUM_ELEM; i++) begin
         qlow = div_quo[i][WORD_BITS-1:0];
         big  = div_quo[i][QUO_BITS-1] | div_quo[i][WORD_BITS-1];
         neg  = div_side.neg[i] & (div_quo[i] != '0);
         if (div_side.transpose) begin
            res[i] = div_side.elem[i];
         end else if (div_side.singular) begin
            res[i] = '0;
         end else if (neg) begin
            res[i] = big ? SAT_NEG : (~qlow + WORD_BITS'(1));
         end else begin
            res[i] = big ? SAT_POS : qlow;
         end
      end
      rsp_data_in.out_r0c0       = res[0];
      rsp_data_in.out_r0c1       = res[1];
      rsp_data_in.out_r0c2       = res[2];
      rsp_data_in.out_r1c0       = res[3];
      rsp_data_in.out_r1c1       = res[4];
      rsp_data_in.out_r1c2       = res[5];
      rsp_data_in.out_r2c0       = res[6];
      rsp_data_in.out_r2c1       = res[7];
      rsp_data_in.out_r2c2       = res[8];
      rsp_data_in.singular       = div_side.singular;
      rsp_data_in.used_transpose = div_side.transpose;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= div_valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

>>> dv/rotation_matrix_inverse_3x3_core_checker.sv
`timescale 1ns / 1ps

module rotation_matrix_inverse_3x3_core_checker import rmi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  rmi_req_type req_data,
   input  logic        rsp_strobe,
   input  rmi_rsp_type rsp_data,
   output int          failures,
   output int          pending
);

   localparam int W = 200;

   rmi_rsp_type inverse_queue [$];

   function automatic rmi_rsp_type inverse_of(rmi_req_type m);
      logic [NUM_ELEM-1:0][WORD_BITS-1:0] elems;
      logic [NUM_ELEM-1:0][WORD_BITS-1:0] o;
      logic signed [W-1:0] a [NUM_ELEM];
      logic signed [W-1:0] c [NUM_ELEM];
      logic signed [W-1:0] det, one3, scaled;
      logic [W-1:0] dmag, cmag, num, q;
      logic neg, sing, trn;
      elems = m;
      for (int i = 0; i < NUM_ELEM; i++)
         a[i] = W'(signed'(elems[NUM_ELEM-1-i]));
      for (int i = 0; i < NUM_ELEM; i++)
         c[i] = a[COF_SEL[i][0]] * a[COF_SEL[i][1]] - a[COF_SEL[i][2]] * a[COF_SEL[i][3]];
      det = a[0] * c[0] + a[1] * c[3] + a[2] * c[6];
      one3 = W'(1) <<< (3 * FRAC_BITS);
      scaled = det * 1000;
      sing = 1'b0;
      trn = 1'b0;
      o = '0;
      if (scaled > one3 * 999 && scaled < one3 * 1001) begin
         trn = 1'b1;
         for (int i = 0; i < NUM_ELEM; i++)
            o[NUM_ELEM-1-i] = elems[NUM_ELEM-1-((i % 3) * 3 + i / 3)];
      end else if (det == 0) begin
         sing = 1'b1;
      end else begin
         dmag = (det < 0) ? -det : det;
         for (int i = 0; i < NUM_ELEM; i++) begin
            cmag = (c[i] < 0) ? -c[i] : c[i];
            num = (cmag << (2 * FRAC_BITS + 1)) + dmag;
            q = num / (dmag << 1);
            neg = ((c[i] < 0) != (det < 0)) && (q != 0);
            if (!neg && q > W'(SAT_POS))
               o[NUM_ELEM-1-i] = SAT_POS;
            else if (neg && q >= W'(SAT_NEG))
               o[NUM_ELEM-1-i] = SAT_NEG;
            else
               o[NUM_ELEM-1-i] = neg ? WORD_BITS'(-q) : WORD_BITS'(q);
         end
      end
      return rmi_rsp_type'({o, sing, trn});
   endfunction

   assign pending = inverse_queue.size();

   always @(posedge clock) begin
      logic [NUM_ELEM-1:0][WORD_BITS-1:0] got, want;
      rmi_rsp_type exp_rsp;
      int errs;
      errs = 0;
      if (!reset) begin
         if (start && !busy)
            inverse_queue.push_back(inverse_of(req_data));
         if (rsp_strobe) begin
            if (inverse_queue.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               errs = errs + 1;
            end else begin
               exp_rsp = inverse_queue.pop_front();
               got = rsp_data[$bits(rmi_rsp_type)-1:2];
               want = exp_rsp[$bits(rmi_rsp_type)-1:2];
               for (int i = 0; i < NUM_ELEM; i++)
                  if (got[NUM_ELEM-1-i] !== want[NUM_ELEM-1-i]) begin
                     $display("%0t: element %0d expected %h actual %h", $time, i,
                        want[NUM_ELEM-1-i], got[NUM_ELEM-1-i]);
                     errs = errs + 1;
                  end
               if (rsp_data.singular !== exp_rsp.singular) begin
                  $display("%0t: singular expected %b actual %b", $time,
                     exp_rsp.singular, rsp_data.singular);
                  errs = errs + 1;
               end
               if (rsp_data.used_transpose !== exp_rsp.used_transpose) begin
                  $display("%0t: used_transpose expected %b actual %b", $time,
                     exp_rsp.used_transpose, rsp_data.used_transpose);
                  errs = errs + 1;
               end
            end
         end
      end
      if (reset)
         failures <= 0;
      else
         failures <= failures + errs;
   end

endmodule

>>> dv/rotation_matrix_inverse_3x3_core_test.sv
`timescale 1ns / 1ps

module rotation_matrix_inverse_3x3_core_test import rmi_pkg::*;;

   localparam logic [31:0] ONE = 32'h0100_0000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   rmi_req_type req_data;
   logic        rsp_strobe;
   rmi_rsp_type rsp_data;
   int          failures;
   int          pending;
   int          idle_pct;

   rotation_matrix_inverse_3x3_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data));

   rotation_matrix_inverse_3x3_core_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .failures(failures), .pending(pending));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // request handed over at the edge with start high and busy low
   task automatic send_matrix(input logic [31:0] e [9]);
      logic b;
      start <= 1'b1;
      req_data <= rmi_req_type'({e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]});
      forever begin
         @(negedge clock);
         b = busy;
         @(posedge clock);
         if (!b) break;
      end
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_data <= rmi_req_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom});
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic send_diag(input logic [31:0] d0, d1, d2);
      logic [31:0] e [9];
      e = '{d0, 0, 0, 0, d1, 0, 0, 0, d2};
      send_matrix(e);
   endtask

   function automatic logic [31:0] small_q(input int mag);
      return 32'($signed($urandom_range(2 * mag)) - mag);
   endfunction

   task automatic send_random(input int kind);
      logic [31:0] e [9];
      int p [3];
      int k;
      case (kind)
         0: for (int i = 0; i < 9; i++) e[i] = $urandom;
         1: for (int i = 0; i < 9; i++) e[i] = small_q(32'h0400_0000);
         2: begin
            // signed permutation, perturbed: rotation window and its edges
            p = '{0, 1, 2};
            k = $urandom_range(2);
            p[0] = k; p[k] = 0;
            k = 1 + $urandom_range(1);
            p[1] = p[k]; p[k] = (k == 1) ? p[1] : 1;
            p = '{p[0], p[1], 3 - p[0] - p[1]};
            for (int i = 0; i < 9; i++) e[i] = small_q(1 << $urandom_range(14));
            for (int r = 0; r < 3; r++)
               e[r * 3 + p[r]] = e[r * 3 + p[r]] + ($urandom_range(1) ? ONE : -ONE);
         end
         3: begin
            for (int i = 0; i < 6; i++) e[i] = small_q(32'h0200_0000);
            for (int i = 6; i < 9; i++) e[i] = e[i - 3 * (1 + $urandom_range(1))];
            if ($urandom_range(1)) for (int i = 6; i < 9; i++) e[i] = 0;
         end
         default: begin
            for (int i = 0; i < 9; i++) e[i] = small_q(1 << $urandom_range(20));
            e[0] = small_q(32'h0100_0000) | 1;
            e[4] = small_q(32'h0100_0000) | 1;
         end
      endcase
      send_matrix(e);
   endtask

   initial begin
      logic [31:0] e [9];
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      idle_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_diag(ONE, ONE, ONE);
      send_diag(0, 0, 0);
      send_diag(ONE, ONE, 32'd1);
      send_diag(ONE, ONE, -32'd1);
      send_diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_diag(32'h0100_0000, 32'h0100_0000, 32'h0100_4189);
      send_diag(32'h0100_0000, 32'h0100_0000, 32'h00ff_be77);
      send_diag(32'h0100_0000, 32'h0100_0000, 32'h0100_4200);
      send_diag(32'h0100_0000, 32'h0100_0000, 32'h00ff_bd00);
      send_diag(-ONE, ONE, ONE);
      send_diag(32'h0200_0000, 32'h0080_0000, 32'h0400_0000);
      e = '{0, ONE, 0, -ONE, 0, 0, 0, 0, ONE};
      send_matrix(e);
      e = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
      send_matrix(e);
      e = '{ONE, 32'h0200_0000, 32'h0300_0000, 32'h0400_0000, 32'h0500_0000,
            32'h0600_0000, 32'h0700_0000, 32'h0800_0000, 32'h0900_0000};
      send_matrix(e);
      e = '{32'hffff_ffff, 0, 0, 0, 32'hffff_ffff, 0, 0, 0, 32'hffff_ffff};
      send_matrix(e);
      e = '{32'h0000_0001, 32'h8000_0000, 0, 32'h7fff_ffff, 32'h0000_0001, 0, 0, 0, ONE};
      send_matrix(e);

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 62 : (ph == 3) ? 14 : 0;
         for (int n = 0; n < 350; n++) begin
            send_random($urandom_range(4));
            if (ph == 2 && n == 175) begin
               start <= 1'b0;
               while (pending != 0) @(posedge clock);
            end
         end
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
